[hdl/r2y_pkg.sv]
// Shared types and constants for the RGB to YUV 4:2:0 converter.
`default_nettype none
package r2y_pkg;

  localparam int CNT_W  = 12;
  localparam int CFG_W  = 13;
  localparam int SUM_W  = 9;
  localparam int PAIR_W = 3 * SUM_W;

  // Widest frame the counters and the line store cover.
  localparam int MAX_WIDTH = 4096;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd1920;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd1080;
  localparam logic [CFG_W-1:0] HEIGHT_MAX   = 13'd4096;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_index_t;

  // Luma weights.
  localparam logic [7:0] KY_R = 8'd54;
  localparam logic [7:0] KY_G = 8'd183;
  localparam logic [7:0] KY_B = 8'd18;

  // Chroma weights, magnitudes; signs are applied in the sum.
  localparam logic signed [18:0] KU_R = 19'sd29;
  localparam logic signed [18:0] KU_G = 19'sd99;
  localparam logic signed [18:0] KU_B = 19'sd128;
  localparam logic signed [18:0] KV_R = 19'sd128;
  localparam logic signed [18:0] KV_G = 19'sd116;
  localparam logic signed [18:0] KV_B = 19'sd12;
  localparam logic signed [18:0] CHROMA_OFS = 19'sd32768;

endpackage
`default_nettype wire

[hdl/rgb_to_yuv420_converter_core.sv]
// Streaming BGR to YUV 4:2:0 converter with a line store of even-row pair sums.
// Throughput: one pixel per cycle while not stalled; the line store is read once and
// written at most once per pixel.
// Stall: one pipeline enable, in_ready = !out_valid || out_ready.
// Reset: synchronous, clears counters, pair sum, stage valids and loads 1920x1080.
// The line store holds no reset value; it is written by every even row before use.
`default_nettype none
module rgb_to_yuv420_converter_core
  import r2y_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [0:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [7:0]       blue,
  input  wire logic [7:0]       green,
  input  wire logic [7:0]       red,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [7:0]            luma,
  output logic                  chroma_valid,
  output logic [7:0]            chroma_u,
  output logic [7:0]            chroma_v,
  output logic                  frame_end
);

  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int IDX_W      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam logic [CNT_W:0] DEPTH_C = (CNT_W + 1)'(LINE_DEPTH);
  localparam logic [CFG_W:0] WMAX_C  = (CFG_W + 1)'(MAX_WIDTH);

  // Configuration
  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_WIDTH:  frame_width  <= cfg_data;
        REG_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [CFG_W:0] eff_w;
  logic [CFG_W:0] eff_h;

  always_comb begin
    if (frame_width == '0)                       eff_w = (CFG_W + 1)'(1);
    else if ({1'b0, frame_width} > WMAX_C)       eff_w = WMAX_C;
    else                                         eff_w = {1'b0, frame_width};
    if (frame_height == '0)                      eff_h = (CFG_W + 1)'(1);
    else if (frame_height > HEIGHT_MAX)          eff_h = {1'b0, HEIGHT_MAX};
    else                                         eff_h = {1'b0, frame_height};
  end

  // Pipeline control
  logic en;
  logic accept;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;
  assign accept   = in_valid && en;

  // Stage 0: counters, pair sum, line store access
  logic [CNT_W-1:0]  column_count, column_count_next;
  logic [CNT_W-1:0]  row_count, row_count_next;
  logic [PAIR_W-1:0] pair_sum, pair_sum_next;
  logic              last_col, last_row, pair_done;
  logic [CNT_W:0]    half_col;
  logic [CNT_W:0]    half_wrap;
  logic [IDX_W-1:0]  line_idx;

  assign last_col  = {{(CFG_W + 1 - CNT_W){1'b0}}, column_count} >= (eff_w - 1'b1);
  assign last_row  = {{(CFG_W + 1 - CNT_W){1'b0}}, row_count} >= (eff_h - 1'b1);
  assign pair_done = column_count[0] || last_col;
  assign half_col  = {2'b00, column_count[CNT_W-1:1]};
  assign half_wrap = (half_col >= DEPTH_C) ? (half_col - DEPTH_C) : half_col;
  assign line_idx  = (LINE_DEPTH > 1) ? half_wrap[IDX_W-1:0] : '0;

  always_comb begin
    if (!column_count[0]) begin
      pair_sum_next = {1'b0, red, 1'b0, green, 1'b0, blue};
    end else begin
      pair_sum_next[SUM_W-1:0]          = pair_sum[SUM_W-1:0] + SUM_W'(blue);
      pair_sum_next[2*SUM_W-1:SUM_W]    = pair_sum[2*SUM_W-1:SUM_W] + SUM_W'(green);
      pair_sum_next[PAIR_W-1:2*SUM_W]   = pair_sum[PAIR_W-1:2*SUM_W] + SUM_W'(red);
    end
    if (last_col) begin
      column_count_next = '0;
      row_count_next    = last_row ? '0 : row_count + 1'b1;
    end else begin
      column_count_next = column_count + 1'b1;
      row_count_next    = row_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      pair_sum     <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
      pair_sum     <= pair_sum_next;
    end
  end

  logic [PAIR_W-1:0] line_mem [LINE_DEPTH];
  logic [PAIR_W-1:0] mem_q;

  // Even rows store the pair; odd rows read it back through the registered mem_q.
  always_ff @(posedge clk) begin
    if (accept) begin
      if (pair_done && !row_count[0]) line_mem[line_idx] <= pair_sum_next;
      mem_q <= line_mem[line_idx];
    end
  end

  // Stage 1
  logic              s1_valid, s1_add, s1_emit, s1_end;
  logic [15:0]       s1_luma_sum;
  logic [PAIR_W-1:0] s1_pair;

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (en) s1_valid <= accept;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_luma_sum <= 16'(KY_R) * 16'(red) + 16'(KY_G) * 16'(green) +
                     16'(KY_B) * 16'(blue);
      s1_pair     <= pair_sum_next;
      s1_add      <= pair_done && row_count[0];
      s1_emit     <= pair_done && (row_count[0] || last_row);
      s1_end      <= last_col && last_row;
    end
  end

  // Stage 2: block sums, divide by four
  logic [SUM_W:0] blk_b, blk_g, blk_r;
  logic [PAIR_W-1:0] line_add;

  assign line_add = s1_add ? mem_q : '0;
  assign blk_b = {1'b0, s1_pair[SUM_W-1:0]} + {1'b0, line_add[SUM_W-1:0]};
  assign blk_g = {1'b0, s1_pair[2*SUM_W-1:SUM_W]} + {1'b0, line_add[2*SUM_W-1:SUM_W]};
  assign blk_r = {1'b0, s1_pair[PAIR_W-1:2*SUM_W]} + {1'b0, line_add[PAIR_W-1:2*SUM_W]};

  logic       s2_valid, s2_emit, s2_end;
  logic [7:0] s2_luma, s2_b, s2_g, s2_r;

  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else if (en) s2_valid <= s1_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_luma <= s1_luma_sum[15:8];
      s2_emit <= s1_emit;
      s2_end  <= s1_end;
      s2_b    <= blk_b[SUM_W:2];
      s2_g    <= blk_g[SUM_W:2];
      s2_r    <= blk_r[SUM_W:2];
    end
  end

  // Stage 3: weighted chroma sums with offset; result is never negative
  logic signed [18:0] sb, sg, sr, wu, wv;

  assign sb = signed'({11'b0, s2_b});
  assign sg = signed'({11'b0, s2_g});
  assign sr = signed'({11'b0, s2_r});
  assign wu = CHROMA_OFS + KU_B * sb - KU_R * sr - KU_G * sg;
  assign wv = CHROMA_OFS + KV_R * sr - KV_G * sg - KV_B * sb;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= s2_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      luma         <= s2_luma;
      chroma_valid <= s2_emit;
      chroma_u     <= s2_emit ? wu[15:8] : 8'd0;
      chroma_v     <= s2_emit ? wv[15:8] : 8'd0;
      frame_end    <= s2_end;
    end
  end

`ifndef ASSERT_OFF
  a_chroma_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !chroma_valid |-> chroma_u == 8'd0 && chroma_v == 8'd0)
    else $error("chroma nonzero without a completed block");

  a_end_has_chroma: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> chroma_valid)
    else $error("frame end without a completed block");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !en |=> s1_valid && $stable(s1_pair))
    else $error("stage one lost its beat under stall");

  a_counter_advance: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(column_count) && $stable(row_count))
    else $error("counters moved without an accepted beat");
`endif

endmodule
`default_nettype wire

[tb/tb_rgb_to_yuv420_converter_core.sv]
// Self-checking testbench for the streaming RGB to YUV 4:2:0 converter core.
`timescale 1ns / 100ps
module tb_rgb_to_yuv420_converter_core;
  import r2y_pkg::*;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int RANDOM_PIXELS = 1250;
  localparam int LINE_SLOTS    = 2048;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  typedef struct packed {
    logic [7:0] luma;
    logic       chroma_valid;
    logic [7:0] chroma_u;
    logic [7:0] chroma_v;
    logic       frame_end;
  } yuv_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  reg_index_t       cfg_index = REG_WIDTH;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [7:0]       blue = '0;
  logic [7:0]       green = '0;
  logic [7:0]       red = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [7:0]       luma;
  logic             chroma_valid;
  logic [7:0]       chroma_u;
  logic [7:0]       chroma_v;
  logic             frame_end;

  rgb_to_yuv420_converter_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .blue         (blue),
    .green        (green),
    .red          (red),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .luma         (luma),
    .chroma_valid (chroma_valid),
    .chroma_u     (chroma_u),
    .chroma_v     (chroma_v),
    .frame_end    (frame_end)
  );

  always #6 clk = ~clk;

  // Converter mirror: registers, counters, running pair sum and even-row line store.
  logic [CFG_W-1:0] cfg_width = WIDTH_RESET;
  logic [CFG_W-1:0] cfg_height = HEIGHT_RESET;
  logic [11:0]      col_count = '0;
  logic [11:0]      row_count = '0;
  logic [26:0]      pair_acc = '0;
  logic [26:0]      pair_line [0:LINE_SLOTS-1];

  pixel_t pixel_backlog [$];
  yuv_t   yuv_expected [$];
  pixel_t next_pixel;
  yuv_t   want;
  yuv_t   got;
  int     pixels_queued = 0;
  int     yuv_received = 0;
  int     random_pixels = 0;
  int     mismatch_count = 0;
  int     cycle_count = 0;
  int     hold_left = 0;
  bit     hold_done = 1'b0;
  bit     pixel_taken = 1'b0;
  bit     calm = 1'b0;

  function automatic int unsigned eff_width();
    if (cfg_width == 0) return 1;
    if (cfg_width > 4096) return 4096;
    return cfg_width;
  endfunction

  function automatic int unsigned eff_height();
    if (cfg_height == 0) return 1;
    if (cfg_height > HEIGHT_MAX) return HEIGHT_MAX;
    return cfg_height;
  endfunction

  // Pixels still needed to close the current frame, counters taken as they stand.
  function automatic int unsigned frame_left();
    int unsigned ew, eh, row_pixels, rows;
    ew = eff_width();
    eh = eff_height();
    row_pixels = (col_count >= ew - 1) ? 1 : ew - col_count;
    rows = (row_count >= eh - 1) ? 0 : eh - 1 - row_count;
    return row_pixels + rows * ew;
  endfunction

  task automatic convert_pixel(input pixel_t px);
    int unsigned ew, eh;
    int          sb, sg, sr, wu, wv;
    bit          last_col, last_row, emit;
    logic [10:0] slot;
    logic [26:0] held;
    yuv_t        res;
    ew = eff_width();
    eh = eff_height();
    last_col = col_count >= ew - 1;
    last_row = row_count >= eh - 1;
    slot = col_count[11:1];
    emit = 1'b0;
    res = '0;
    res.luma = 8'((54 * px.red + 183 * px.green + 18 * px.blue) >> 8);
    if (!col_count[0]) begin
      pair_acc = {1'b0, px.red, 1'b0, px.green, 1'b0, px.blue};
    end else begin
      pair_acc = {9'(pair_acc[26:18] + px.red), 9'(pair_acc[17:9] + px.green),
                  9'(pair_acc[8:0] + px.blue)};
    end
    if (col_count[0] || last_col) begin
      sb = pair_acc[8:0];
      sg = pair_acc[17:9];
      sr = pair_acc[26:18];
      if (row_count[0]) begin
        held = pair_line[slot];
        sb += held[8:0];
        sg += held[17:9];
        sr += held[26:18];
        emit = 1'b1;
      end else begin
        pair_line[slot] = pair_acc;
        emit = last_row;
      end
      if (emit) begin
        sb = sb >> 2;
        sg = sg >> 2;
        sr = sr >> 2;
        // Offset keeps both sums non-negative, so bits 15:8 are floor(sum/256)+128.
        wu = -29 * sr - 99 * sg + 128 * sb + 32768;
        wv = 128 * sr - 116 * sg - 12 * sb + 32768;
        res.chroma_valid = 1'b1;
        res.chroma_u = wu[15:8];
        res.chroma_v = wv[15:8];
      end
    end
    res.frame_end = last_col && last_row;
    if (last_col) begin
      col_count = '0;
      row_count = last_row ? '0 : row_count + 12'd1;
    end else begin
      col_count = col_count + 12'd1;
    end
    yuv_expected.push_back(res);
  endtask

  task automatic flag_result(input string what, input yuv_t exp_v, input yuv_t act_v);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t %s: luma %0d/%0d cv %0b/%0b u %0d/%0d v %0d/%0d fe %0b/%0b (exp/got)",
               $time, what, exp_v.luma, act_v.luma, exp_v.chroma_valid, act_v.chroma_valid,
               exp_v.chroma_u, act_v.chroma_u, exp_v.chroma_v, act_v.chroma_v,
               exp_v.frame_end, act_v.frame_end);
  endtask

  // Check output beats, then predict the pixel taken on this edge.
  always @(posedge clk) begin
    pixel_taken <= !rst && in_valid && in_ready;
    if (!rst && out_valid && out_ready) begin
      yuv_received <= yuv_received + 1;
      got.luma = luma;
      got.chroma_valid = chroma_valid;
      got.chroma_u = chroma_u;
      got.chroma_v = chroma_v;
      got.frame_end = frame_end;
      if (yuv_expected.size() == 0) begin
        flag_result("unexpected beat", '0, got);
      end else begin
        want = yuv_expected.pop_front();
        if (got.luma !== want.luma || got.chroma_valid !== want.chroma_valid ||
            got.chroma_u !== want.chroma_u || got.chroma_v !== want.chroma_v ||
            got.frame_end !== want.frame_end)
          flag_result("mismatch", want, got);
      end
    end
    if (!rst && in_valid && in_ready) convert_pixel('{blue, green, red});
  end

  // Pixel driver: hold the beat until taken, then maybe idle.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || pixel_taken) begin
      if (pixel_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= 27)) begin
        next_pixel = pixel_backlog.pop_front();
        in_valid <= 1'b1;
        blue <= next_pixel.blue;
        green <= next_pixel.green;
        red <= next_pixel.red;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result sink: random stalls plus one long hold-off while pixels keep coming.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && yuv_received > 200 && pixel_backlog.size() > 30) begin
      out_ready <= 1'b0;
      hold_left <= 80;
      hold_done <= 1'b1;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= 27);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_rgb_to_yuv420_converter_core: FAIL");
      $finish;
    end
  end

  task automatic queue_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r);
    pixel_backlog.push_back('{b, g, r});
    pixels_queued++;
  endtask

  task automatic queue_random(input int unsigned n);
    logic [2:0] corner;
    repeat (n) begin
      corner = $urandom_range(0, 7);
      if ($urandom_range(0, 4) == 0)
        queue_pixel({8{corner[0]}}, {8{corner[1]}}, {8{corner[2]}});
      else
        queue_pixel($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
      random_pixels++;
    end
  endtask

  // Wait until every queued pixel has come back, then let the pipeline drain.
  task automatic settle();
    while (yuv_received < pixels_queued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [CFG_W-1:0] val);
    settle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == REG_WIDTH) cfg_width = val;
    else cfg_height = val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int unsigned w, h, n, k, frames, pick;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Solid blue 2x2 block: chroma U at its top.
    write_reg(REG_WIDTH, 2);
    write_reg(REG_HEIGHT, 2);
    repeat (4) queue_pixel(8'd255, 8'd0, 8'd0);

    // Odd width and odd height: short edge blocks, primaries and extremes.
    write_reg(REG_WIDTH, 3);
    write_reg(REG_HEIGHT, 3);
    queue_pixel(8'd0, 8'd0, 8'd0);
    queue_pixel(8'd255, 8'd255, 8'd255);
    queue_pixel(8'd0, 8'd0, 8'd255);
    queue_pixel(8'd0, 8'd255, 8'd255);
    queue_pixel(8'd255, 8'd255, 8'd0);
    queue_pixel(8'd0, 8'd0, 8'd255);
    queue_pixel(8'd255, 8'd0, 8'd255);
    queue_pixel(8'd0, 8'd255, 8'd0);
    queue_pixel(8'd128, 8'd64, 8'd32);

    // Zero-sized frame acts as 1x1.
    write_reg(REG_WIDTH, 0);
    write_reg(REG_HEIGHT, 0);
    queue_pixel(8'd255, 8'd255, 8'd255);

    // Oversized width, then shrink mid-row so the column is already past the end.
    write_reg(REG_WIDTH, 8191);
    write_reg(REG_HEIGHT, 4096);
    queue_random(5);
    write_reg(REG_WIDTH, 2);
    write_reg(REG_HEIGHT, 1);
    queue_random(frame_left());

    // Full-size width, then width 1 mid-row on an even row.
    write_reg(REG_WIDTH, 4096);
    write_reg(REG_HEIGHT, 8191);
    queue_random(3);
    write_reg(REG_WIDTH, 1);
    write_reg(REG_HEIGHT, 2);
    queue_random(frame_left());

    random_pixels = 0;
    while (random_pixels < RANDOM_PIXELS) begin
      calm = (random_pixels >= 500 && random_pixels < 800);
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        // Wide frame cut short: still on row 0, so a width change is safe.
        write_reg(REG_WIDTH, $urandom_range(0, 1) ? 13'd4096 : 13'd8191);
        write_reg(REG_HEIGHT, $urandom_range(1, 4));
        queue_random($urandom_range(1, 60));
        write_reg(REG_WIDTH, $urandom_range(0, 12));
        queue_random(frame_left());
      end else if (pick == 1) begin
        // Tall frame cut short by a height change.
        write_reg(REG_WIDTH, $urandom_range(1, 4));
        write_reg(REG_HEIGHT, $urandom_range(0, 1) ? 13'd4096 : 13'd8191);
        queue_random($urandom_range(1, 80));
        write_reg(REG_HEIGHT, $urandom_range(0, 6));
        queue_random(frame_left());
      end else begin
        w = (pick <= 14) ? $urandom_range(0, 8) :
            (pick <= 18) ? $urandom_range(9, 40) : $urandom_range(41, 200);
        h = (w > 40) ? $urandom_range(0, 2) : $urandom_range(0, 6);
        if ($urandom_range(0, 4) != 0) write_reg(REG_WIDTH, w);
        if ($urandom_range(0, 4) != 0) write_reg(REG_HEIGHT, h);
        frames = $urandom_range(1, 3);
        for (int f = 0; f < frames; f++) begin
          n = eff_width() * eff_height();
          if (f == frames - 1 && $urandom_range(0, 3) == 0) begin
            k = $urandom_range(1, n);
            queue_random(k);
            settle();
            // Width may only move on an even row: odd rows read what it stored.
            if (!row_count[0] && $urandom_range(0, 1))
              write_reg(REG_WIDTH, $urandom_range(0, 12));
            else
              write_reg(REG_HEIGHT, $urandom_range(0, 6));
            queue_random(frame_left());
          end else begin
            queue_random(n);
          end
        end
      end
    end
    calm = 1'b0;

    while (yuv_received < pixels_queued) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && yuv_expected.size() == 0)
      $display("tb_rgb_to_yuv420_converter_core: PASS");
    else
      $display("tb_rgb_to_yuv420_converter_core: FAIL");
    $finish;
  end

endmodule

[rgb_to_yuv420_converter_core.f]
hdl/r2y_pkg.sv
hdl/rgb_to_yuv420_converter_core.sv
tb/tb_rgb_to_yuv420_converter_core.sv
